[src/assert_macros.svh]
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold whenever the antecedent holds, in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dipa_pkg.sv]
// Shared types, constants and the character classifier of the IPv4 text parser.
package dipa_pkg;

  localparam int QUEUE_DEPTH  = 2;
  localparam int RESULT_DEPTH = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;

  typedef struct packed {
    logic       is_nul;
    logic       is_dec;
    logic       is_hex;
    logic       is_x;
    logic       is_dot;
    logic       is_space;
    logic       is_zero;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [2:0]  part_count;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    logic        lo_hex;
    logic        up_hex;
    lo_hex     = (c >= CHAR_LO_A) && (c <= CHAR_LO_F);
    up_hex     = (c >= CHAR_UP_A) && (c <= CHAR_UP_F);
    k.is_nul   = (c == CHAR_NUL);
    k.is_dec   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    k.is_hex   = k.is_dec || lo_hex || up_hex;
    k.is_x     = (c == CHAR_LO_X) || (c == CHAR_UP_X);
    k.is_dot   = (c == CHAR_DOT);
    k.is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    k.is_zero  = (c == CHAR_ZERO);
    // Letters a-f and A-F carry their value minus nine in the low nibble.
    k.digit    = k.is_dec ? c[3:0] : c[3:0] + 4'd9;
    return k;
  endfunction

endpackage

[src/dotted_ipv4_address_parser.sv]
// Top level of the dotted IPv4 address text parser.
//
//   Channel   Beat                 Handshake           Fields
//   input     one character        push / full         char_code
//   result    one parsed address   empty / pop         address_ok, address, part_count
//
// One character is taken every cycle while no NUL waits for room in the result
// queue; the parser updates its state with one shift-add per character. A pushed
// NUL passes through the character queue into the result queue for popping.
// Reset (rst, synchronous) empties both queues and returns the parser to the start
// of a string. A stalled result side stops only NUL beats in the parser; characters
// ahead of such a NUL keep flowing, and those behind it fill the character queue.
module dotted_ipv4_address_parser #(
  parameter int QUEUE_DEPTH  = dipa_pkg::QUEUE_DEPTH,
  parameter int RESULT_DEPTH = dipa_pkg::RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  logic        push,
  output logic        full,
  output logic        address_ok,
  output logic [31:0] address,
  output logic [2:0]  part_count,
  output logic        empty,
  input  logic        pop
);

  logic                  head_valid;
  logic                  head_take;
  dipa_pkg::char_class_t head_class;
  dipa_pkg::result_t     result;

  dipa_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .push       (push),
    .full       (full),
    .head_valid (head_valid),
    .head_class (head_class),
    .head_take  (head_take)
  );

  dipa_back #(
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_class   (head_class),
    .head_take    (head_take),
    .result       (result),
    .result_empty (empty),
    .result_pop   (pop)
  );

  assign address_ok = result.ok;
  assign address    = result.address;
  assign part_count = result.part_count;

endmodule

[src/dipa_fifo.sv]
// Small first-word-fall-through queue used between the parser stages.
module dipa_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/dipa_front.sv]
// Front stage: classifies each incoming character and queues it for the parser.
module dipa_front #(
  parameter int QUEUE_DEPTH = dipa_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            char_code,
  input  logic                  push,
  output logic                  full,
  output logic                  head_valid,
  output dipa_pkg::char_class_t head_class,
  input  logic                  head_take
);

  dipa_pkg::char_class_t in_class;
  logic                  queue_empty;

  assign in_class   = dipa_pkg::classify(char_code);
  assign head_valid = !queue_empty;

  dipa_fifo #(
    .item_t (dipa_pkg::char_class_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_class_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_class),
    .full  (full),
    .pop   (head_take),
    .rdata (head_class),
    .empty (queue_empty)
  );

endmodule

[src/dipa_back.sv]
// Back stage: the parse state machine and the result queue.
module dipa_back #(
  parameter int RESULT_DEPTH = dipa_pkg::RESULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  dipa_pkg::char_class_t head_class,
  output logic                  head_take,
  output dipa_pkg::result_t     result,
  output logic                  result_empty,
  input  logic                  result_pop
);

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_AFTER_ZERO = 3'd1;
  localparam logic [2:0] PH_DIGITS     = 3'd2;
  localparam logic [2:0] PH_TRAILING   = 3'd3;
  localparam logic [2:0] PH_FAILED     = 3'd4;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [1:0]        radix;
  logic [1:0]        radix_next;
  logic [31:0]       current_value;
  logic [31:0]       current_value_next;
  logic [31:0]       parts [3];
  logic [31:0]       parts_next [3];
  logic [1:0]        parts_stored;
  logic [1:0]        parts_stored_next;

  logic              result_full;
  logic [31:0]       digit_ext;
  logic [31:0]       stepped_value;
  logic              digit_ok;
  logic              run_digit;
  dipa_pkg::result_t done;
  logic              phase_ok;
  logic              range_ok;
  logic [31:0]       merged;

  // A terminating NUL needs room in the result queue; other beats never stall.
  assign head_take = head_valid && (!head_class.is_nul || !result_full);

  assign digit_ext = {28'd0, head_class.digit};
  assign digit_ok  = (radix == RADIX_HEX) ? head_class.is_hex : head_class.is_dec;

  always_comb begin
    case (radix)
      RADIX_HEX: stepped_value = {current_value[27:0], head_class.digit};
      RADIX_OCT: stepped_value = {current_value[28:0], 3'b000} + digit_ext;
      default:   stepped_value = {current_value[28:0], 3'b000}
                               + {current_value[30:0], 1'b0} + digit_ext;
    endcase
  end

  // Assemble the result that a NUL would deliver in the current state.
  always_comb begin
    phase_ok = (phase == PH_AFTER_ZERO) || (phase == PH_DIGITS) || (phase == PH_TRAILING);
    case (parts_stored)
      2'd0: begin
        range_ok = 1'b1;
        merged   = current_value;
      end
      2'd1: begin
        range_ok = (current_value[31:24] == '0);
        merged   = current_value | {parts[0][7:0], 24'd0};
      end
      2'd2: begin
        range_ok = (current_value[31:16] == '0);
        merged   = current_value | {parts[0][7:0], 24'd0} | {parts[1][15:0], 16'd0};
      end
      default: begin
        range_ok = (current_value[31:8] == '0);
        merged   = current_value | {parts[0][7:0], 24'd0} | {parts[1][15:0], 16'd0}
                 | {parts[2][23:0], 8'd0};
      end
    endcase
    done.ok         = phase_ok && range_ok;
    done.address    = done.ok ? merged : 32'd0;
    done.part_count = done.ok ? {1'b0, parts_stored} + 3'd1 : 3'd0;
  end

  always_comb begin
    phase_next         = phase;
    radix_next         = radix;
    current_value_next = current_value;
    parts_next         = parts;
    parts_stored_next  = parts_stored;
    run_digit          = 1'b0;

    if (head_take) begin
      if (head_class.is_nul) begin
        phase_next         = PH_START;
        radix_next         = RADIX_DEC;
        current_value_next = '0;
        parts_stored_next  = '0;
        for (int i = 0; i < 3; i++) begin
          parts_next[i] = '0;
        end
      end else begin
        case (phase)
          PH_START: begin
            if (!head_class.is_dec) begin
              phase_next = PH_FAILED;
            end else if (head_class.is_zero) begin
              current_value_next = '0;
              radix_next         = RADIX_OCT;
              phase_next         = PH_AFTER_ZERO;
            end else begin
              current_value_next = digit_ext;
              radix_next         = RADIX_DEC;
              phase_next         = PH_DIGITS;
            end
          end
          PH_AFTER_ZERO: begin
            if (head_class.is_x) begin
              radix_next = RADIX_HEX;
              phase_next = PH_DIGITS;
            end else begin
              run_digit = 1'b1;
            end
          end
          PH_DIGITS: begin
            run_digit = 1'b1;
          end
          PH_TRAILING: begin
            phase_next = PH_TRAILING;
          end
          default: begin
            phase_next = PH_FAILED;
          end
        endcase

        if (run_digit) begin
          if (digit_ok) begin
            current_value_next = stepped_value;
            phase_next         = PH_DIGITS;
          end else if (head_class.is_dot) begin
            if (parts_stored == 2'd3) begin
              phase_next = PH_FAILED;
            end else begin
              parts_next[parts_stored] = current_value;
              parts_stored_next        = parts_stored + 2'd1;
              current_value_next       = '0;
              radix_next               = RADIX_DEC;
              phase_next               = PH_START;
            end
          end else if (head_class.is_space) begin
            phase_next = PH_TRAILING;
          end else begin
            phase_next = PH_FAILED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      radix         <= RADIX_DEC;
      current_value <= '0;
      parts_stored  <= '0;
      for (int i = 0; i < 3; i++) begin
        parts[i] <= '0;
      end
    end else begin
      phase         <= phase_next;
      radix         <= radix_next;
      current_value <= current_value_next;
      parts_stored  <= parts_stored_next;
      parts         <= parts_next;
    end
  end

  dipa_fifo #(
    .item_t (dipa_pkg::result_t),
    .DEPTH  (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (head_take && head_class.is_nul),
    .wdata (done),
    .full  (result_full),
    .pop   (result_pop),
    .rdata (result),
    .empty (result_empty)
  );

endmodule

[src/dipa_checker.sv]
// Port-level checks on the IPv4 address parser, bound to its top level.
`include "assert_macros.svh"

module dipa_checker (
  input logic        clk,
  input logic        rst,
  input logic        address_ok,
  input logic [31:0] address,
  input logic [2:0]  part_count,
  input logic        empty,
  input logic        pop
);

  `ASSERT_SAME(a_reject_clears, clk, rst, !empty && !address_ok, (address == 32'd0) && (part_count == 3'd0), "rejected result carries data")
  `ASSERT_SAME(a_ok_has_parts, clk, rst, !empty && address_ok, (part_count >= 3'd1) && (part_count <= 3'd4), "accepted result has a bad part count")
  `ASSERT_SAME(a_empty_after_reset, clk, rst, $past(rst), empty, "result waiting right after reset")
  `ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(address) && $stable(address_ok), "stalled result changed")

endmodule

bind dotted_ipv4_address_parser dipa_checker u_checker (.*);
